// ===== sv/blf_pkg.sv =====
`default_nettype none

package blf_pkg;

  // Frame and window limits.
  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_RADIUS  = 8;
  localparam int WT_DEPTH    = 1024;
  localparam int STORE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ADDR_XW     = ADDR_W + 1;
  localparam int WT_IDX_W    = $clog2(WT_DEPTH);

  // Field and register widths.
  localparam int PIX_W     = 16;
  localparam int OUT_W     = 17;
  localparam int WIDTH_W   = 13;
  localparam int HEIGHT_W  = 16;
  localparam int RAD_W     = 4;
  localparam int SS_W      = 16;
  localparam int RS_W      = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam int COUNT_W   = 28;
  localparam int COL_W     = 12;
  localparam int LAG_W     = 16;
  localparam int OFF_W     = 5;
  localparam int SW_W      = 41;
  localparam int SUM_W     = 57;
  localparam int NUM_W     = SUM_W + 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SCALE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE   = 3'd5;

  // Input function codes.
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // BT.709 luma coefficients in Q0.16.
  localparam logic [13:0] LUMA_R = 14'd13933;
  localparam logic [15:0] LUMA_G = 16'd46871;
  localparam logic [12:0] LUMA_B = 13'd4732;

  // exp(-1/64) in Q0.32.
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4228380000;

  // Effective configuration seen by the filter datapath.
  typedef struct packed {
    logic [WIDTH_W-1:0]  w;
    logic [HEIGHT_W-1:0] h;
    logic [RAD_W-1:0]    rad;
    logic [SS_W-1:0]     ss;
    logic [RS_W-1:0]     rs;
    logic                mode;
    logic [LAG_W-1:0]    lag;
  } cfg_t;

  // One center to be filtered.
  typedef struct packed {
    logic [ADDR_W-1:0]   c_slot;
    logic [COL_W-1:0]    cx;
    logic [HEIGHT_W-1:0] cy;
    logic                fin;
  } job_t;

  typedef logic [PIX_W-1:0] wt_table_t [WT_DEPTH];

  // Builds the exp(-k/64) table in Q0.16 by repeated multiplication.
  function automatic wt_table_t build_wt();
    wt_table_t   tab;
    logic [63:0] t;
    logic [63:0] v;
    t = 64'h1_0000_0000;
    for (int k = 0; k < WT_DEPTH; k++) begin
      v = (t + 64'd32768) >> 16;
      tab[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      t = (t * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
    end
    return tab;
  endfunction

  localparam wt_table_t WT_TABLE = build_wt();

endpackage

`default_nettype wire

// ===== sv/blf_if.sv =====
`default_nettype none

// Pixel request channel.
interface blf_in_if import blf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;

  modport source(output valid, func, red, green, blue, input ready);
  modport sink(input valid, func, red, green, blue, output ready);
endinterface

// Filtered pixel channel.
interface blf_out_if import blf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_red;
  logic signed [OUT_W-1:0] out_green;
  logic signed [OUT_W-1:0] out_blue;
  logic                    frame_last;

  modport source(output valid, out_red, out_green, out_blue, frame_last, input ready);
  modport sink(input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

`default_nettype wire

// ===== sv/blf_queue.sv =====
`default_nettype none

module blf_queue import blf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      not_empty,
  output logic      empty,
  output job_t      head
);

  job_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign not_empty = (count_r != 2'd0);
  assign empty     = (count_r == 2'd0);
  assign head      = entry_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== sv/blf_front.sv =====
`default_nettype none

module blf_front import blf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  blf_in_if.sink                    in_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
  input  wire logic                 q_empty,
  input  wire logic                 back_busy,
  output logic                      push,
  output job_t                      push_job,
  output cfg_t                      cfg,
  input  wire logic [ADDR_W-1:0]    rd_addr,
  output logic [3*PIX_W-1:0]        rd_data
);

  // Configuration registers.
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [RAD_W-1:0]    radius_r;
  logic [SS_W-1:0]     ss_r;
  logic [RS_W-1:0]     rs_r;
  logic                mode_r;
  logic                dirty_r;

  // Derived frame geometry.
  logic [WIDTH_W-1:0]  w_eff_r, w_eff_nxt;
  logic [HEIGHT_W-1:0] h_eff_r, h_eff_nxt;
  logic [RAD_W-1:0]    rad_eff_r, rad_eff_nxt;
  logic [LAG_W-1:0]    lag_r, lag_nxt;
  logic [COUNT_W-1:0]  total_r, total_nxt;

  // Frame counters.
  logic [COUNT_W-1:0]  recv_r, recv_nxt;
  logic [ADDR_W-1:0]   sp_r, sp_nxt;
  logic [COUNT_W-1:0]  emitted_r, emitted_nxt;
  logic [COL_W-1:0]    ecol_r, ecol_nxt;
  logic [HEIGHT_W-1:0] erow_r, erow_nxt;
  logic [ADDR_W-1:0]   cslot_r, cslot_nxt;

  logic [3*PIX_W-1:0]  mem [STORE_DEPTH];
  logic [3*PIX_W-1:0]  rd_data_r;

  logic               accept;
  logic               is_pix;
  logic               emit;
  logic               fin;
  logic               restart;
  logic [COUNT_W-1:0] recv_n;

  assign in_ch.ready = !dirty_r && q_empty && !back_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  // Geometry is registered from the configuration registers and follows them in the next cycle.
  always_comb begin
    if (width_r == '0) begin
      w_eff_nxt = WIDTH_W'(1);
    end else if (width_r > WIDTH_W'(MAX_WIDTH)) begin
      w_eff_nxt = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff_nxt = width_r;
    end
    h_eff_nxt   = (height_r == '0) ? HEIGHT_W'(1) : height_r;
    rad_eff_nxt = (radius_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_r;
    lag_nxt     = LAG_W'(rad_eff_nxt * w_eff_nxt + LAG_W'(rad_eff_nxt));
    total_nxt   = COUNT_W'(w_eff_nxt) * COUNT_W'(h_eff_nxt);
  end

  // Classify the request: store a pixel and decide whether a center is due.
  always_comb begin
    is_pix = (in_ch.func == FUNC_PIXEL) && (recv_r < total_r);
    recv_n = recv_r + COUNT_W'(is_pix);
    emit   = (emitted_r < total_r) && (recv_n > emitted_r) &&
             ((recv_n == total_r) || ((recv_n - emitted_r) > COUNT_W'(lag_r)));
    fin    = (emitted_r == total_r - COUNT_W'(1));
    push   = accept && emit;
    push_job.c_slot = cslot_r;
    push_job.cx     = ecol_r;
    push_job.cy     = erow_r;
    push_job.fin    = fin;
  end

  // Counter updates.
  always_comb begin
    restart     = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) ||
                  (cfg_index == REG_IMAGE_HEIGHT) || (cfg_index == REG_WINDOW_RADIUS));
    recv_nxt    = recv_r;
    sp_nxt      = sp_r;
    emitted_nxt = emitted_r;
    ecol_nxt    = ecol_r;
    erow_nxt    = erow_r;
    cslot_nxt   = cslot_r;
    if (accept && is_pix) begin
      recv_nxt = recv_n;
      sp_nxt   = (sp_r == ADDR_W'(STORE_DEPTH - 1)) ? '0 : sp_r + ADDR_W'(1);
    end
    if (push) begin
      emitted_nxt = emitted_r + COUNT_W'(1);
      cslot_nxt   = (cslot_r == ADDR_W'(STORE_DEPTH - 1)) ? '0 : cslot_r + ADDR_W'(1);
      if ({1'b0, ecol_r} == w_eff_r - WIDTH_W'(1)) begin
        ecol_nxt = '0;
        erow_nxt = erow_r + HEIGHT_W'(1);
      end else begin
        ecol_nxt = ecol_r + COL_W'(1);
      end
    end
    if ((push && fin) || restart) begin
      recv_nxt    = '0;
      sp_nxt      = '0;
      emitted_nxt = '0;
      ecol_nxt    = '0;
      erow_nxt    = '0;
      cslot_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_W'(1920);
      height_r  <= HEIGHT_W'(1080);
      radius_r  <= RAD_W'(3);
      ss_r      <= SS_W'(2048);
      rs_r      <= RS_W'(204800);
      mode_r    <= 1'b0;
      dirty_r   <= 1'b1;
      w_eff_r   <= '0;
      h_eff_r   <= '0;
      rad_eff_r <= '0;
      lag_r     <= '0;
      total_r   <= '0;
      recv_r    <= '0;
      sp_r      <= '0;
      emitted_r <= '0;
      ecol_r    <= '0;
      erow_r    <= '0;
      cslot_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:   width_r  <= cfg_wdata[WIDTH_W-1:0];
          REG_IMAGE_HEIGHT:  height_r <= cfg_wdata[HEIGHT_W-1:0];
          REG_WINDOW_RADIUS: radius_r <= cfg_wdata[RAD_W-1:0];
          REG_SPATIAL_SCALE: ss_r     <= cfg_wdata[SS_W-1:0];
          REG_RANGE_SCALE:   rs_r     <= cfg_wdata[RS_W-1:0];
          REG_OUTPUT_MODE:   mode_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      dirty_r   <= cfg_we;
      w_eff_r   <= w_eff_nxt;
      h_eff_r   <= h_eff_nxt;
      rad_eff_r <= rad_eff_nxt;
      lag_r     <= lag_nxt;
      total_r   <= total_nxt;
      recv_r    <= recv_nxt;
      sp_r      <= sp_nxt;
      emitted_r <= emitted_nxt;
      ecol_r    <= ecol_nxt;
      erow_r    <= erow_nxt;
      cslot_r   <= cslot_nxt;
    end
  end

  // Circular pixel store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && is_pix) begin
      mem[sp_r] <= {in_ch.red, in_ch.green, in_ch.blue};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

  assign cfg.w    = w_eff_r;
  assign cfg.h    = h_eff_r;
  assign cfg.rad  = rad_eff_r;
  assign cfg.ss   = ss_r;
  assign cfg.rs   = rs_r;
  assign cfg.mode = mode_r;
  assign cfg.lag  = lag_r;

endmodule

`default_nettype wire

// ===== sv/blf_div.sv =====
`default_nettype none

// Restoring divider, three channels sharing one divisor, one bit a cycle.
module blf_div import blf_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [2:0][NUM_W-1:0]      num,
  input  wire logic [SW_W-1:0]            den,
  output logic      [2:0][PIX_W-1:0]      quo,
  output logic                            done
);

  logic                     busy_r;
  logic                     done_r;
  logic [$clog2(PIX_W)-1:0] cnt_r;
  logic [SW_W-1:0]          den_r;
  logic [2:0][SW_W-1:0]     rem_r, rem_nxt;
  logic [2:0][PIX_W-1:0]    sh_r, sh_nxt;
  logic [SW_W:0]            trial [3];
  logic [2:0]               ge;

  // One quotient bit per channel per cycle.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      trial[ch]   = {rem_r[ch], sh_r[ch][PIX_W-1]};
      ge[ch]      = (trial[ch] >= {1'b0, den_r});
      rem_nxt[ch] = ge[ch] ? SW_W'(trial[ch] - {1'b0, den_r}) : trial[ch][SW_W-1:0];
      sh_nxt[ch]  = {sh_r[ch][PIX_W-2:0], ge[ch]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(PIX_W))'(PIX_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The quotient fits the pixel width, so the high part starts below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      for (int ch = 0; ch < 3; ch++) begin
        rem_r[ch] <= num[ch][PIX_W+SW_W-1:PIX_W];
        sh_r[ch]  <= num[ch][PIX_W-1:0];
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
    end
  end

  assign quo  = sh_r;
  assign done = done_r;

endmodule

`default_nettype wire

// ===== sv/blf_back.sv =====
`default_nettype none

module blf_back import blf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               q_valid,
  input  wire job_t               q_head,
  output logic                    q_pop,
  output logic                    busy,
  output logic [ADDR_W-1:0]       rd_addr,
  input  wire logic [3*PIX_W-1:0] rd_data,
  blf_out_if.source               out_ch
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CTR   = 6'b000010,
    S_TAPS  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } bstate_t;

  bstate_t state_r, state_nxt;
  job_t    job_r;

  // Window walker.
  logic signed [OFF_W-1:0] dy_r, dx_r, rad_s;
  logic [ADDR_W-1:0]       row_addr_r, addr_r;
  logic [ADDR_XW-1:0]      start_sum, row_sum;
  logic [ADDR_W-1:0]       start_addr, row_next;
  logic signed [HEIGHT_W+1:0] ny;
  logic signed [COL_W+2:0]    nx;
  logic                    in_img, tap_valid;
  logic [RAD_W-1:0]        adx, ady;
  logic [7:0]              d2;

  // Tap pipeline.
  logic                    v1_r, c1_r, v2_r, c2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic [7:0]              d2_1_r;
  logic [3*PIX_W-1:0]      pix2_r, pix3_r, pix4_r, pix5_r, pix6_r, pix7_r;
  logic [29:0]             pr2_r;
  logic [31:0]             pg2_r;
  logic [28:0]             pb2_r;
  logic [17:0]             sidx2_r;
  logic [23:0]             sprod;
  logic [32:0]             ysum;
  logic [PIX_W-1:0]        yn, dl, ws;
  logic [PIX_W-1:0]        yc_r, dl3_r, ws3_r, ws4_r, ws5_r, ws6_r, wr6_r, wr;
  logic [3*PIX_W-1:0]      cpix_r;
  logic [31:0]             dlsq4_r, wt7_r, wt8_r;
  logic [55:0]             rprod;
  logic [21:0]             ridx5_r;
  logic [47:0]             prod8_r [3];
  logic                    pipe_busy;

  // Sums and divider hookup.
  logic [SW_W-1:0]         sw_r;
  logic [SUM_W-1:0]        s_r [3];
  logic                    div_start, div_done;
  logic [2:0][NUM_W-1:0]   div_num;
  logic [2:0][PIX_W-1:0]   div_quo;

  // Result register.
  logic                    ovalid_r;
  logic [OUT_W-1:0]        ored_r, ogreen_r, oblue_r;
  logic                    olast_r;
  logic                    load_out;
  logic [PIX_W-1:0]        base [3];
  logic [PIX_W-1:0]        cch [3];
  logic [OUT_W-1:0]        oval [3];

  assign rad_s = $signed({1'b0, cfg.rad});
  assign busy  = (state_r == S_CTR) || (state_r == S_TAPS) || (state_r == S_DRAIN);
  assign q_pop = (state_r == S_IDLE) && q_valid;

  // First window address, and the step to the next window row.
  always_comb begin
    start_sum  = {1'b0, q_head.c_slot} + ADDR_XW'(STORE_DEPTH) - ADDR_XW'(cfg.lag);
    start_addr = (start_sum >= ADDR_XW'(STORE_DEPTH)) ?
                 ADDR_W'(start_sum - ADDR_XW'(STORE_DEPTH)) : ADDR_W'(start_sum);
    row_sum    = {1'b0, row_addr_r} + ADDR_XW'(cfg.w);
    row_next   = (row_sum >= ADDR_XW'(STORE_DEPTH)) ?
                 ADDR_W'(row_sum - ADDR_XW'(STORE_DEPTH)) : ADDR_W'(row_sum);
  end

  // Neighbor position check and squared distance.
  always_comb begin
    ny        = $signed({2'b00, job_r.cy}) + (HEIGHT_W+2)'(dy_r);
    nx        = $signed({3'b000, job_r.cx}) + (COL_W+3)'(dx_r);
    in_img    = !ny[HEIGHT_W+1] && (ny < $signed({2'b00, cfg.h})) &&
                !nx[COL_W+2] && (nx < $signed({2'b00, cfg.w}));
    tap_valid = (state_r == S_TAPS) && in_img;
    adx       = dx_r[OFF_W-1] ? RAD_W'(-dx_r) : RAD_W'(dx_r);
    ady       = dy_r[OFF_W-1] ? RAD_W'(-dy_r) : RAD_W'(dy_r);
    d2        = 8'(adx) * 8'(adx) + 8'(ady) * 8'(ady);
    rd_addr   = (state_r == S_CTR) ? job_r.c_slot : addr_r;
  end

  // Datapath combinational pieces between the tap pipeline registers.
  always_comb begin
    sprod = 24'(d2_1_r) * 24'(cfg.ss);
    ysum  = 33'(pr2_r) + 33'(pg2_r) + 33'(pb2_r) + 33'd32768;
    yn    = ysum[31:16];
    dl    = (yn > yc_r) ? yn - yc_r : yc_r - yn;
    ws    = (sidx2_r < 18'(WT_DEPTH)) ? WT_TABLE[sidx2_r[WT_IDX_W-1:0]] : '0;
    rprod = 56'(dlsq4_r) * 56'(cfg.rs);
    wr    = (ridx5_r < 22'(WT_DEPTH)) ? WT_TABLE[ridx5_r[WT_IDX_W-1:0]] : '0;
    pipe_busy = v1_r || v2_r || v3_r || v4_r || v5_r || v6_r || v7_r || v8_r;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) state_nxt = S_CTR;
      end
      S_CTR: state_nxt = S_TAPS;
      S_TAPS: begin
        if ((dx_r == rad_s) && (dy_r == rad_s)) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          if (sw_r == '0) begin
            state_nxt = S_EMIT;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      v6_r    <= 1'b0;
      v7_r    <= 1'b0;
      v8_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= tap_valid || (state_r == S_CTR);
      v2_r    <= v1_r;
      v3_r    <= v2_r && !c2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      v6_r    <= v5_r;
      v7_r    <= v6_r;
      v8_r    <= v7_r;
    end
  end

  // Window walk: the center first, then the taps row by row.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r      <= q_head;
      dy_r       <= -rad_s;
      dx_r       <= -rad_s;
      row_addr_r <= start_addr;
      addr_r     <= start_addr;
    end else if (state_r == S_TAPS) begin
      if (dx_r == rad_s) begin
        dx_r       <= -rad_s;
        dy_r       <= dy_r + OFF_W'(1);
        row_addr_r <= row_next;
        addr_r     <= row_next;
      end else begin
        dx_r   <= dx_r + OFF_W'(1);
        addr_r <= (addr_r == ADDR_W'(STORE_DEPTH - 1)) ? '0 : addr_r + ADDR_W'(1);
      end
    end
  end

  // Tap pipeline payload: luma, spatial and range weights, products.
  always_ff @(posedge clk) begin
    c1_r    <= (state_r == S_CTR);
    d2_1_r  <= d2;
    c2_r    <= c1_r;
    pix2_r  <= rd_data;
    pr2_r   <= 30'(rd_data[3*PIX_W-1:2*PIX_W]) * 30'(LUMA_R);
    pg2_r   <= 32'(rd_data[2*PIX_W-1:PIX_W]) * 32'(LUMA_G);
    pb2_r   <= 29'(rd_data[PIX_W-1:0]) * 29'(LUMA_B);
    sidx2_r <= sprod[23:6];
    if (v2_r && c2_r) begin
      yc_r   <= yn;
      cpix_r <= pix2_r;
    end
    pix3_r  <= pix2_r;
    dl3_r   <= dl;
    ws3_r   <= ws;
    pix4_r  <= pix3_r;
    ws4_r   <= ws3_r;
    dlsq4_r <= 32'(dl3_r) * 32'(dl3_r);
    pix5_r  <= pix4_r;
    ws5_r   <= ws4_r;
    ridx5_r <= rprod[55:34];
    pix6_r  <= pix5_r;
    ws6_r   <= ws5_r;
    wr6_r   <= wr;
    pix7_r  <= pix6_r;
    wt7_r   <= 32'(ws6_r) * 32'(wr6_r);
    wt8_r   <= wt7_r;
    prod8_r[0] <= 48'(wt7_r) * 48'(pix7_r[3*PIX_W-1:2*PIX_W]);
    prod8_r[1] <= 48'(wt7_r) * 48'(pix7_r[2*PIX_W-1:PIX_W]);
    prod8_r[2] <= 48'(wt7_r) * 48'(pix7_r[PIX_W-1:0]);
  end

  // Weighted sums, cleared at the start of each center.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sw_r <= '0;
      for (int ch = 0; ch < 3; ch++) s_r[ch] <= '0;
    end else if (v8_r) begin
      sw_r <= sw_r + SW_W'(wt8_r);
      for (int ch = 0; ch < 3; ch++) s_r[ch] <= s_r[ch] + SUM_W'(prod8_r[ch]);
    end
  end

  // Rounded mean: (sum + weight/2) / weight.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      div_num[ch] = NUM_W'(s_r[ch]) + NUM_W'(sw_r[SW_W-1:1]);
    end
  end

  blf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (sw_r),
    .quo   (div_quo),
    .done  (div_done)
  );

  // Base or detail value per channel.
  always_comb begin
    cch[0] = cpix_r[3*PIX_W-1:2*PIX_W];
    cch[1] = cpix_r[2*PIX_W-1:PIX_W];
    cch[2] = cpix_r[PIX_W-1:0];
    for (int ch = 0; ch < 3; ch++) begin
      base[ch] = (sw_r == '0) ? cch[ch] : div_quo[ch];
      oval[ch] = cfg.mode ? ({1'b0, cch[ch]} - {1'b0, base[ch]}) : {1'b0, base[ch]};
    end
    load_out = (state_r == S_EMIT) && (!ovalid_r || out_ch.ready);
  end

  // Output register decouples the result from the next center.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= load_out || (ovalid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ored_r   <= oval[0];
      ogreen_r <= oval[1];
      oblue_r  <= oval[2];
      olast_r  <= job_r.fin;
    end
  end

  assign out_ch.valid      = ovalid_r;
  assign out_ch.out_red    = $signed(ored_r);
  assign out_ch.out_green  = $signed(ogreen_r);
  assign out_ch.out_blue   = $signed(oblue_r);
  assign out_ch.frame_last = olast_r;

endmodule

`default_nettype wire

// ===== sv/bilateral_luma_filter.sv =====
// A center's result follows the request that completes it once the window walk over the
// (2r+1)^2 taps, r being the effective window radius, the tap pipeline drain, any divide
// and the output load are through; the window walk issues one tap a cycle. A request that
// yields a result holds off further requests while the back end walks the single
// pixel-store read port and drains; the next center starts after the output load.
// Reset is synchronous, active low: counters clear and registers take their defaults;
// the pixel store is not cleared.
`default_nettype none

module bilateral_luma_filter import blf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  blf_in_if.sink                    in_ch,
  blf_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic               push;
  job_t               push_job;
  cfg_t               cfg;
  logic               q_empty;
  logic               q_valid;
  logic               q_pop;
  job_t               q_head;
  logic               back_busy;
  logic [ADDR_W-1:0]  rd_addr;
  logic [3*PIX_W-1:0] rd_data;

  // Front end: counters, configuration and the pixel store.
  blf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .back_busy (back_busy),
    .push      (push),
    .push_job  (push_job),
    .cfg       (cfg),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // Pending centers.
  blf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (q_pop),
    .not_empty (q_valid),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back end: window walk, weighting and normalization.
  blf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .busy    (back_busy),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
